// File: rtl/bpe_pkg.sv
package bpe_pkg;

  localparam int MAX_DEGREE_DEF = 7;
  localparam int MAX_TERMS_DEF  = 64;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] REG_X_DEGREE = 2'd0;
  localparam logic [1:0] REG_Y_DEGREE = 2'd1;

  localparam logic [2:0] DEGREE_RESET = 3'd2;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_XPOW,
    ST_YPOW,
    ST_MONO,
    ST_TERM,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_XP,
    TAG_YP,
    TAG_MONO,
    TAG_TERM
  } tag_t;

endpackage

// File: rtl/bpe_ram.sv
module bpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bpe_qmul.sv
module bpe_qmul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res,
  output logic               ovf
);

  logic signed [63:0] prod;
  logic        [47:0] shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // dropping the low 16 bits of a two's complement value rounds toward minus infinity
  assign shifted = prod[63:16];

  always_comb begin
    ovf = !((&shifted[47:31]) || !(|shifted[47:31]));
    if (ovf) begin
      res = shifted[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res = shifted[31:0];
    end
  end

endmodule

// File: rtl/bivariate_polynomial_evaluator.sv
// coefficient write: taken in the cycle of start, busy stays low, no result
// evaluate: busy while the sequencer runs, then a result with done
// the single shared multiplier sets the run length: one product per cycle, two per term
// throughput: one transaction at a time, a new start is taken in the done cycle
// rst (synchronous) sets both degrees to 2 and idles the sequencer
// coefficient store is not cleared by reset
module bivariate_polynomial_evaluator
  import bpe_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int MAX_TERMS  = MAX_TERMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       request,
  output logic       done,
  output res_t       result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int AW    = $clog2(MAX_TERMS);
  localparam int SW    = $clog2(MAX_TERMS + 1);
  localparam int ACC_W = 32 + $clog2(MAX_TERMS);

  state_t state, state_next;
  tag_t   tag, tag_next;
  logic [DW-1:0] tag_idx, tag_idx_next;
  logic [DW-1:0] k, k_next;
  logic [DW-1:0] i, i_next;
  logic [DW-1:0] j, j_next;
  logic [SW-1:0] slot, slot_next;
  logic [2:0]    x_degree, y_degree;

  logic [DW-1:0] dx, dy, dmax, jmax;
  logic          last_cell, keep;

  logic signed [31:0] xq, yq;
  logic signed [31:0] xp [MAX_DEGREE+1];
  logic signed [31:0] yp [MAX_DEGREE+1];
  logic signed [31:0] mul_a, mul_b, mul_res;
  logic               mul_ovf;
  logic               sat_flag;
  logic [ACC_W-1:0]   acc;
  logic               acc_ovf;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic          accept_eval;

  assign busy        = (state != ST_IDLE);
  assign accept_eval = start && !busy && (request.cmd == CMD_EVAL);

  assign dx   = ({29'b0, x_degree} > 32'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(x_degree);
  assign dy   = ({29'b0, y_degree} > 32'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(y_degree);
  assign dmax = (dx > dy) ? dx : dy;
  // inner limit keeps i+j within the larger degree
  assign jmax = (dy < (dmax - i)) ? dy : (dmax - i);
  assign last_cell = (i == dx) && (j == jmax);
  assign keep = !((i == '0) && (j == '0)) && (slot < SW'(MAX_TERMS));

  bpe_ram #(
    .WIDTH(32),
    .DEPTH(MAX_TERMS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(request.coef_index)),
    .wdata(request.coef_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bpe_qmul u_qmul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .res(mul_res),
    .ovf(mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tag      <= TAG_NONE;
      done     <= 1'b0;
      x_degree <= DEGREE_RESET;
      y_degree <= DEGREE_RESET;
    end else begin
      state <= state_next;
      tag   <= tag_next;
      done  <= (state == ST_FIN);
      if (cfg_we) begin
        case (cfg_index)
          REG_X_DEGREE: x_degree <= cfg_data;
          REG_Y_DEGREE: y_degree <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_idx <= tag_idx_next;
    k       <= k_next;
    i       <= i_next;
    j       <= j_next;
    slot    <= slot_next;
    if (accept_eval) begin
      xq       <= {{8{request.x_value[15]}}, request.x_value, 8'b0};
      yq       <= {{8{request.y_value[15]}}, request.y_value, 8'b0};
      xp[0]    <= ONE_Q16;
      yp[0]    <= ONE_Q16;
      sat_flag <= 1'b0;
    end else if ((tag != TAG_NONE) && mul_ovf) begin
      sat_flag <= 1'b1;
    end
    if (tag == TAG_XP) begin
      xp[tag_idx] <= mul_res;
    end
    if (tag == TAG_YP) begin
      yp[tag_idx] <= mul_res;
    end
    if (state == ST_LOAD0) begin
      acc <= {{(ACC_W-32){ram_rdata[31]}}, ram_rdata};
    end else if (tag == TAG_TERM) begin
      acc <= acc + {{(ACC_W-32){mul_res[31]}}, mul_res};
    end
    if (state == ST_FIN) begin
      result.saturated <= sat_flag || acc_ovf;
      if (acc_ovf) begin
        result.prediction <= acc[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        result.prediction <= acc[31:0];
      end
    end
  end

  assign acc_ovf = !((&acc[ACC_W-1:31]) || !(|acc[ACC_W-1:31]));

  always_comb begin
    state_next   = state;
    tag_next     = TAG_NONE;
    tag_idx_next = k;
    k_next       = k;
    i_next       = i;
    j_next       = j;
    slot_next    = slot;
    mul_a        = mul_res;
    mul_b        = xq;
    ram_raddr    = slot[AW-1:0];
    ram_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        // address 0 is read here so the constant term is ready in the load cycle
        ram_raddr = '0;
        if (start) begin
          if (request.cmd == CMD_WRITE) begin
            ram_we = ({26'b0, request.coef_index} < 32'(MAX_TERMS));
          end else begin
            state_next = ST_LOAD0;
          end
        end
      end
      ST_LOAD0: begin
        i_next    = '0;
        j_next    = '0;
        k_next    = DW'(1);
        slot_next = SW'(1);
        if (dx != '0) begin
          state_next = ST_XPOW;
        end else if (dy != '0) begin
          state_next = ST_YPOW;
        end else begin
          state_next = ST_MONO;
        end
      end
      ST_XPOW: begin
        mul_a    = (k == DW'(1)) ? ONE_Q16 : mul_res;
        mul_b    = xq;
        tag_next = TAG_XP;
        if (k == dx) begin
          k_next     = DW'(1);
          state_next = (dy != '0) ? ST_YPOW : ST_MONO;
        end else begin
          k_next = k + DW'(1);
        end
      end
      ST_YPOW: begin
        mul_a    = (k == DW'(1)) ? ONE_Q16 : mul_res;
        mul_b    = yq;
        tag_next = TAG_YP;
        if (k == dy) begin
          state_next = ST_MONO;
        end else begin
          k_next = k + DW'(1);
        end
      end
      ST_MONO: begin
        mul_a = (i == '0) ? ONE_Q16 : xp[i];
        mul_b = (j == '0) ? ONE_Q16 : yp[j];
        if (keep) begin
          tag_next   = TAG_MONO;
          state_next = ST_TERM;
        end else if (last_cell || (slot >= SW'(MAX_TERMS))) begin
          state_next = ST_DRAIN;
        end else if (j == jmax) begin
          i_next = i + DW'(1);
          j_next = '0;
        end else begin
          j_next = j + DW'(1);
        end
      end
      ST_TERM: begin
        // monomial from the previous cycle times the coefficient read at this slot
        mul_a     = mul_res;
        mul_b     = ram_rdata;
        tag_next  = TAG_TERM;
        slot_next = slot + SW'(1);
        if (last_cell || (slot_next == SW'(MAX_TERMS))) begin
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_MONO;
          if (j == jmax) begin
            i_next = i + DW'(1);
            j_next = '0;
          end else begin
            j_next = j + DW'(1);
          end
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FIN)
    else $error("result strobe without a finished evaluation");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE) && !busy)
    else $error("coefficient write outside idle");

  a_term_after_mono: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TERM) |-> $past(state) == ST_MONO)
    else $error("term multiply without a monomial and coefficient read");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONO || state == ST_TERM) |-> slot <= SW'(MAX_TERMS))
    else $error("slot counter past the store depth");

  a_acc_from_term: assert property (@(posedge clk) disable iff (rst)
    (tag == TAG_TERM) |-> $past(state) == ST_TERM)
    else $error("accumulate without a term multiply");
`endif

endmodule

// File: dv/bivariate_polynomial_evaluator_tb.sv
`timescale 1ns / 1ps

module bivariate_polynomial_evaluator_tb;
  import bpe_pkg::*;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PERCENT = 27;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 70;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       request = '0;
  logic       done;
  res_t       result;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  // shadow of the block state
  logic [2:0]         deg_x = DEGREE_RESET;
  logic [2:0]         deg_y = DEGREE_RESET;
  logic signed [31:0] coef_mem [MAX_TERMS_DEF];

  req_t pend_q [$];
  res_t value_q [$];

  int sent_cnt = 0;
  int eval_cnt = 0;
  int clip_cnt = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int stall_cnt = 0;
  logic keep_item;

  bivariate_polynomial_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // q16.16 product, floored, clipped to 32 bits
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                inout logic clip);
    longint prod;
    prod = longint'(a) * longint'(b);
    prod = prod >>> 16;
    if (prod > SAT_HI) begin
      clip = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (prod < SAT_LO) begin
      clip = 1'b1;
      return 32'sh8000_0000;
    end
    return 32'(prod);
  endfunction

  function automatic res_t poly_value(input logic signed [15:0] xv,
                                      input logic signed [15:0] yv);
    logic signed [31:0] xpow [0:MAX_DEGREE_DEF];
    logic signed [31:0] ypow [0:MAX_DEGREE_DEF];
    logic signed [31:0] xq, yq, mono, term;
    int dx, dy, dmax, slot;
    longint acc;
    logic clip;
    res_t r;
    dx = (int'(deg_x) > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(deg_x);
    dy = (int'(deg_y) > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(deg_y);
    dmax = (dx > dy) ? dx : dy;
    xq = {{8{xv[15]}}, xv, 8'h00};
    yq = {{8{yv[15]}}, yv, 8'h00};
    clip = 1'b0;
    xpow[0] = ONE_Q16;
    ypow[0] = ONE_Q16;
    for (int i = 1; i <= dx; i++) xpow[i] = fx_mul(xpow[i-1], xq, clip);
    for (int j = 1; j <= dy; j++) ypow[j] = fx_mul(ypow[j-1], yq, clip);
    acc = longint'(coef_mem[0]);
    slot = 1;
    for (int i = 0; i <= dx; i++) begin
      for (int j = 0; j <= dy; j++) begin
        if ((i != 0 || j != 0) && (i + j <= dmax) && (slot < MAX_TERMS_DEF)) begin
          mono = fx_mul(xpow[i], ypow[j], clip);
          term = fx_mul(coef_mem[slot], mono, clip);
          acc += longint'(term);
          slot++;
        end
      end
    end
    if (acc > SAT_HI) begin
      r.prediction = 32'sh7fff_ffff;
      clip = 1'b1;
    end else if (acc < SAT_LO) begin
      r.prediction = 32'sh8000_0000;
      clip = 1'b1;
    end else begin
      r.prediction = 32'(acc);
    end
    r.saturated = clip;
    return r;
  endfunction

  function automatic req_t coef_write(input logic [5:0] slot, input logic signed [31:0] val);
    req_t r;
    r.cmd = CMD_WRITE;
    r.coef_index = slot;
    r.coef_value = val;
    r.x_value = 16'($urandom);
    r.y_value = 16'($urandom);
    return r;
  endfunction

  function automatic req_t eval_at(input logic signed [15:0] xv, input logic signed [15:0] yv);
    req_t r;
    r.cmd = CMD_EVAL;
    r.coef_index = 6'($urandom);
    r.coef_value = 32'($urandom);
    r.x_value = xv;
    r.y_value = yv;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(3))
      0: return 32'($urandom);
      1, 2: return 32'(int'($urandom_range(524287)) - 262144);
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return ONE_Q16;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(127)) - 64);
      default: return 16'(int'($urandom_range(1535)) - 768);
    endcase
  endfunction

  task automatic set_register(input logic [1:0] idx, input logic [2:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_X_DEGREE) deg_x = data;
    else if (idx == REG_Y_DEGREE) deg_y = data;
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || start || value_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [2:0] dx, input logic [2:0] dy, input int n_items);
    int dmax, nterms;
    logic [5:0] slot;
    wait_idle();
    set_register(REG_X_DEGREE, dx);
    set_register(REG_Y_DEGREE, dy);
    if ($urandom_range(1)) begin
      set_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 3'($urandom));
    end
    dmax = (dx > dy) ? int'(dx) : int'(dy);
    nterms = 0;
    for (int i = 0; i <= int'(dx); i++) begin
      for (int j = 0; j <= int'(dy); j++) begin
        if ((i != 0 || j != 0) && i + j <= dmax) nterms++;
      end
    end
    if (nterms > MAX_TERMS_DEF - 1) nterms = MAX_TERMS_DEF - 1;
    // every slot this setting reads gets a value before any evaluation
    for (int s = 0; s <= nterms; s++) pend_q.push_back(coef_write(6'(s), rand_coef()));
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 55) begin
        pend_q.push_back(eval_at(rand_operand(), rand_operand()));
      end else begin
        slot = ($urandom_range(99) < 70) ? 6'($urandom_range(nterms)) : 6'($urandom);
        pend_q.push_back(coef_write(slot, rand_coef()));
      end
    end
  endtask

  // driver: holds a transaction until taken, then picks the next or idles
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      keep_item = 1'b0;
      if (start && !busy) begin
        if (request.cmd == CMD_WRITE) begin
          if (int'(request.coef_index) < MAX_TERMS_DEF) coef_mem[request.coef_index] = request.coef_value;
        end else begin
          value_q.push_back(poly_value(request.x_value, request.y_value));
        end
        void'(pend_q.pop_front());
        sent_cnt++;
      end else if (start) begin
        keep_item = 1'b1;
      end
      if (!keep_item) begin
        if (pend_q.size() != 0 &&
            ((sent_cnt >= 300 && sent_cnt < 500) || $urandom_range(99) >= IDLE_PERCENT)) begin
          start <= 1'b1;
          request <= pend_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (value_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: prediction %h saturated %b",
                   result.prediction, result.saturated);
        end
      end else begin
        res_t want;
        want = value_q.pop_front();
        eval_cnt++;
        if (want.saturated) clip_cnt++;
        if (result.prediction !== want.prediction || result.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on evaluation %0d: expected %h/%b, got %h/%b", eval_cnt,
                     want.prediction, want.saturated, result.prediction, result.saturated);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", stall_cnt);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    for (int s = 0; s < MAX_TERMS_DEF; s++) coef_mem[s] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset degrees 2/2: constant plus five terms
    pend_q.push_back(coef_write(6'd0, ONE_Q16));
    pend_q.push_back(coef_write(6'd1, 32'sh7fff_ffff));
    pend_q.push_back(coef_write(6'd2, 32'sh8000_0000));
    pend_q.push_back(coef_write(6'd3, 32'shffff_ffff));
    pend_q.push_back(coef_write(6'd4, 32'sh0000_0001));
    pend_q.push_back(coef_write(6'd5, 32'sh0001_8000));
    pend_q.push_back(eval_at(16'sh0000, 16'sh0000));
    pend_q.push_back(eval_at(16'sh7fff, 16'sh7fff));
    pend_q.push_back(eval_at(16'sh8000, 16'sh8000));
    pend_q.push_back(eval_at(16'sh7fff, 16'sh8000));
    pend_q.push_back(eval_at(16'sh0100, 16'sh0100));
    pend_q.push_back(eval_at(16'shffff, 16'shffff));
    pend_q.push_back(eval_at(16'sh0080, 16'shff00));
    pend_q.push_back(coef_write(6'd63, 32'sh1234_5678));
    pend_q.push_back(eval_at(16'sh0200, 16'shfe00));
    wait_idle();

    // both degrees zero gives the constant alone; spare indexes change nothing
    set_register(REG_X_DEGREE, 3'd0);
    set_register(REG_Y_DEGREE, 3'd0);
    set_register(REG_SPARE_3, 3'd7);
    set_register(REG_SPARE_2, 3'd5);
    pend_q.push_back(eval_at(16'sh7fff, 16'sh8000));
    pend_q.push_back(eval_at(16'sh1234, 16'sh4321));
    pend_q.push_back(coef_write(6'd0, 32'sh8000_0000));
    pend_q.push_back(eval_at(16'sh8000, 16'sh7fff));

    run_phase(3'd7, 3'd7, ITEMS_PER_PHASE);
    run_phase(3'd7, 3'd0, ITEMS_PER_PHASE);
    run_phase(3'd0, 3'd7, ITEMS_PER_PHASE);
    run_phase(3'd1, 3'd1, ITEMS_PER_PHASE);
    run_phase(3'd3, 3'd5, ITEMS_PER_PHASE);
    run_phase(3'd6, 3'd2, ITEMS_PER_PHASE);
    for (int p = 6; p < RANDOM_PHASES; p++) begin
      run_phase(3'($urandom), 3'($urandom), ITEMS_PER_PHASE);
    end
    wait_idle();

    $display("%0d transactions sent, %0d register writes over %0d degree settings",
             sent_cnt, reg_writes, RANDOM_PHASES + 2);
    $display("%0d evaluations checked, %0d of them clipped, %0d mismatches",
             eval_cnt, clip_cnt, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
